[rtl/epp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epp_pkg
// Shared types, fixed-point constants and small tables of the pose transform.
// ----------------------------------------------------------------------------
package epp_pkg;

  // register indexes in the configuration map
  localparam logic [2:0] REG_SHIFT_X  = 3'd0;
  localparam logic [2:0] REG_SHIFT_Y  = 3'd1;
  localparam logic [2:0] REG_SHIFT_Z  = 3'd2;
  localparam logic [2:0] REG_ANGLE_0  = 3'd3;
  localparam logic [2:0] REG_ANGLE_1  = 3'd4;
  localparam logic [2:0] REG_ANGLE_2  = 3'd5;
  localparam logic [2:0] REG_AXIS     = 3'd6;

  // axis sequence Z,Y,X
  localparam logic [4:0] AXIS_ZYX     = 5'd21;
  localparam logic [4:0] AXIS_MAX     = 5'd26;

  localparam int ANGLE_FRAC = 13;
  localparam int MAT_W      = 30;   // Q28 matrix coefficient
  localparam int TRIG_W     = 32;   // Q30 sin, cos and accumulated matrix
  localparam int CRD_W      = 34;   // CORDIC x, y, z
  localparam int RED_W      = 35;   // reduced angle

  localparam logic signed [RED_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q30    = 32'sd1073741824;

  typedef enum logic [2:0] {
    AU_IDLE, AU_REDUCE, AU_WRAP, AU_FOLD, AU_ROT
  } au_state_e;

  typedef enum logic [2:0] {
    MB_IDLE, MB_START, MB_WAIT, MB_MUL, MB_ACC, MB_NEXT, MB_ROUND
  } mb_state_e;

  // Q30 arctangent of 2^-i
  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [TRIG_W-1:0] v;
    unique case (i)
      5'd0:    v = 32'sd843314857;
      5'd1:    v = 32'sd497837830;
      5'd2:    v = 32'sd263043837;
      5'd3:    v = 32'sd133525159;
      5'd4:    v = 32'sd67021687;
      5'd5:    v = 32'sd33543516;
      5'd6:    v = 32'sd16775851;
      5'd7:    v = 32'sd8388438;
      5'd8:    v = 32'sd4194283;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048576;
      5'd11:   v = 32'sd524288;
      5'd12:   v = 32'sd262144;
      5'd13:   v = 32'sd131072;
      5'd14:   v = 32'sd65536;
      5'd15:   v = 32'sd32768;
      5'd16:   v = 32'sd16384;
      5'd17:   v = 32'sd8192;
      5'd18:   v = 32'sd4096;
      5'd19:   v = 32'sd2048;
      5'd20:   v = 32'sd1024;
      5'd21:   v = 32'sd512;
      5'd22:   v = 32'sd256;
      5'd23:   v = 32'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // base-3 digit n of the axis code, first angle most significant
  function automatic logic [1:0] axis_digit(input logic [4:0] code, input logic [1:0] n);
    logic [4:0] c;
    logic [1:0] d0, d1, d2;
    logic [4:0] rem;
    c   = (code > AXIS_MAX) ? AXIS_ZYX : code;
    d0  = (c >= 5'd18) ? 2'd2 : (c >= 5'd9) ? 2'd1 : 2'd0;
    rem = c - 5'(d0) * 5'd9;
    d1  = (rem >= 5'd6) ? 2'd2 : (rem >= 5'd3) ? 2'd1 : 2'd0;
    d2  = 2'(rem - 5'(d1) * 5'd3);
    unique case (n)
      2'd0:    return d0;
      2'd1:    return d1;
      default: return d2;
    endcase
  endfunction

  function automatic logic [1:0] axis_next(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  // coefficient [k][j] of the elementary rotation about axis a
  function automatic logic signed [TRIG_W-1:0] rot_coef(
    input logic [1:0] a, input logic [1:0] k, input logic [1:0] j,
    input logic signed [TRIG_W-1:0] c, input logic signed [TRIG_W-1:0] s);
    logic [1:0] p, q;
    logic signed [TRIG_W-1:0] v;
    p = axis_next(a);
    q = axis_next(p);
    v = '0;
    if (k == a && j == a) v = ONE_Q30;
    else if (k == p && j == p) v = c;
    else if (k == p && j == q) v = -s;
    else if (k == q && j == p) v = s;
    else if (k == q && j == q) v = c;
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/epp_angle_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epp_angle_unit
// Reduces one angle into [-pi/2, pi/2] and runs an iterative CORDIC,
// one micro-rotation per cycle, giving Q30 sine and cosine.
// ----------------------------------------------------------------------------
module epp_angle_unit #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  signed [ANGLE_BITS-1:0]   angle_i,
  output logic                           done_o,
  output logic signed [epp_pkg::TRIG_W-1:0] sin_o,
  output logic signed [epp_pkg::TRIG_W-1:0] cos_o
);
  import epp_pkg::*;

  localparam int RED_STEPS = (ANGLE_BITS > 16) ? ANGLE_BITS - 15 : 1;
  localparam int RW        = (ANGLE_BITS + 17 > 33) ? ANGLE_BITS + 18 : 34;
  localparam int MAXC      = (CORDIC_STEPS > RED_STEPS) ? CORDIC_STEPS : RED_STEPS;
  localparam int CW        = $clog2(MAXC) + 1;
  localparam logic [RW-1:0] TWO_PI_RW = RW'(TWO_PI_Q30);

  au_state_e state_q, state_d;
  logic [CW-1:0]            cnt_q;
  logic [RW-1:0]            mag_q;
  logic                     sgn_q, neg_q, done_q;
  logic signed [RED_W-1:0]  r_q;
  logic signed [CRD_W-1:0]  x_q, y_q, z_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  logic                     fin;
  logic signed [RW-1:0]     ang_ext;
  logic [RW-1:0]            red_sub;
  logic signed [RED_W-1:0]  r_in, r_wr;
  logic signed [CRD_W-1:0]  xn, yn, zn, dx, dy, atn;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AU_IDLE:   state_d = AU_IDLE;
      AU_REDUCE: if (cnt_q == '0) state_d = AU_WRAP;
      AU_WRAP:   state_d = AU_FOLD;
      AU_FOLD:   state_d = AU_ROT;
      AU_ROT:    if (fin) state_d = AU_IDLE;
      default:   state_d = AU_IDLE;
    endcase
    if (start_i) state_d = AU_REDUCE;
  end

  // control outputs
  always_comb begin
    fin = (state_q == AU_ROT) && (cnt_q == CW'(CORDIC_STEPS - 1));
  end

  // reduction and rotation datapath
  always_comb begin
    ang_ext = RW'(angle_i);
    red_sub = TWO_PI_RW << cnt_q;
    r_in    = RED_W'(mag_q);
    r_in    = sgn_q ? -r_in : r_in;
    r_wr    = r_in;
    if (r_in > PI_Q30) r_wr = r_in - TWO_PI_Q30;
    else if (r_in < -PI_Q30) r_wr = r_in + TWO_PI_Q30;
    dx  = y_q >>> cnt_q;
    dy  = x_q >>> cnt_q;
    atn = CRD_W'(atan_q30(5'(cnt_q)));
    if (z_q >= 0) begin
      xn = x_q - dx; yn = y_q + dy; zn = z_q - atn;
    end else begin
      xn = x_q + dx; yn = y_q - dy; zn = z_q + atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin && !start_i;
      if (start_i) cnt_q <= CW'(RED_STEPS - 1);
      else if (state_q == AU_REDUCE) cnt_q <= cnt_q - 1'b1;
      else if (state_q == AU_FOLD) cnt_q <= '0;
      else if (state_q == AU_ROT) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sgn_q <= angle_i[ANGLE_BITS-1];
      mag_q <= RW'(angle_i[ANGLE_BITS-1] ? -ang_ext : ang_ext) << (30 - ANGLE_FRAC);
    end else begin
      unique case (state_q)
        AU_REDUCE: if (mag_q >= red_sub) mag_q <= mag_q - red_sub;
        AU_WRAP:   r_q <= r_wr;
        AU_FOLD: begin
          x_q <= GAIN_Q30;
          y_q <= '0;
          if (r_q > HALF_PI_Q30) begin
            z_q <= CRD_W'(r_q - PI_Q30); neg_q <= 1'b1;
          end else if (r_q < -HALF_PI_Q30) begin
            z_q <= CRD_W'(r_q + PI_Q30); neg_q <= 1'b1;
          end else begin
            z_q <= CRD_W'(r_q); neg_q <= 1'b0;
          end
        end
        AU_ROT: begin
          x_q <= xn; y_q <= yn; z_q <= zn;
          if (fin) begin
            cos_q <= TRIG_W'(neg_q ? -xn : xn);
            sin_q <= TRIG_W'(neg_q ? -yn : yn);
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule
`default_nettype wire

[rtl/epp_mtx_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epp_mtx_builder
// Composes the three elementary rotations into the Q28 pose matrix with one
// shared multiplier; each product takes a multiply state and then an accumulate state.
// ----------------------------------------------------------------------------
module epp_mtx_builder #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                rebuild_i,
  input  wire  [2:0][ANGLE_BITS-1:0]         angles_i,
  input  wire  [4:0]                         axis_i,
  output logic                               ready_o,
  output logic [8:0][epp_pkg::MAT_W-1:0]     mat_o
);
  import epp_pkg::*;

  mb_state_e state_q, state_d;
  logic [1:0] n_q, i_q, j_q, k_q;
  logic signed [TRIG_W-1:0] acc_q [9];
  logic signed [TRIG_W-1:0] tmp_q [9];
  logic signed [TRIG_W-1:0] s_q, c_q;
  logic signed [63:0]       prod_q;
  logic signed [65:0]       sum_q;
  logic [8:0][MAT_W-1:0]    mat_q;

  logic                     au_start, au_done, last_ijk;
  logic signed [TRIG_W-1:0] au_sin, au_cos, rot_v;
  logic [3:0]               idx_ik, idx_ij;
  logic [1:0]               axis_n;
  logic signed [65:0]       sum_d;

  epp_angle_unit #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (au_start),
    .angle_i ($signed(angles_i[n_q])),
    .done_o  (au_done),
    .sin_o   (au_sin),
    .cos_o   (au_cos)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MB_IDLE:  state_d = MB_IDLE;
      MB_START: state_d = MB_WAIT;
      MB_WAIT:  if (au_done) state_d = MB_MUL;
      MB_MUL:   state_d = MB_ACC;
      MB_ACC:   state_d = last_ijk ? MB_NEXT : MB_MUL;
      MB_NEXT:  state_d = (n_q == 2'd2) ? MB_ROUND : MB_START;
      MB_ROUND: state_d = MB_IDLE;
      default:  state_d = MB_IDLE;
    endcase
    if (rebuild_i) state_d = MB_START;
  end

  // control outputs
  always_comb begin
    au_start = (state_q == MB_START) && !rebuild_i;
    ready_o  = (state_q == MB_IDLE);
    last_ijk = (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2);
  end

  // product operands and accumulation
  always_comb begin
    idx_ik = {1'b0, i_q, 1'b0} + 4'(i_q) + 4'(k_q);
    idx_ij = {1'b0, i_q, 1'b0} + 4'(i_q) + 4'(j_q);
    axis_n = axis_digit(axis_i, n_q);
    rot_v  = rot_coef(axis_n, k_q, j_q, c_q, s_q);
    sum_d  = ((k_q == 2'd0) ? 66'sd0 : sum_q) + 66'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MB_START;
      n_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
    end else begin
      state_q <= state_d;
      if (rebuild_i) begin
        n_q <= '0;
      end else begin
        unique case (state_q)
          MB_WAIT: begin
            i_q <= '0; j_q <= '0; k_q <= '0;
          end
          MB_ACC: begin
            if (k_q != 2'd2) k_q <= k_q + 2'd1;
            else begin
              k_q <= '0;
              if (j_q != 2'd2) j_q <= j_q + 2'd1;
              else begin
                j_q <= '0;
                i_q <= i_q + 2'd1;
              end
            end
          end
          MB_NEXT: if (n_q != 2'd2) n_q <= n_q + 2'd1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MB_START: begin
        if (n_q == 2'd0) begin
          for (int e = 0; e < 9; e++) acc_q[e] <= (e % 4 == 0) ? ONE_Q30 : '0;
        end
      end
      MB_WAIT: if (au_done) begin
        s_q <= au_sin;
        c_q <= au_cos;
      end
      MB_MUL: prod_q <= acc_q[idx_ik] * rot_v;
      MB_ACC: begin
        sum_q <= sum_d;
        if (k_q == 2'd2) tmp_q[idx_ij] <= TRIG_W'((sum_d + (66'sd1 <<< 29)) >>> 30);
      end
      MB_NEXT: for (int e = 0; e < 9; e++) acc_q[e] <= tmp_q[e];
      MB_ROUND: for (int e = 0; e < 9; e++) mat_q[e] <= MAT_W'((acc_q[e] + 32'sd2) >>> 2);
      default: ;
    endcase
  end

  assign mat_o = mat_q;

endmodule
`default_nettype wire

[rtl/epp_point_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epp_point_pipe
// Four-stage R*p+t pipeline: split products, row sums, rounding plus
// translation, saturation. Each stage has its own valid and ready.
// ----------------------------------------------------------------------------
module epp_point_pipe #(
  parameter int COORD_BITS = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               enable_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [2:0][COORD_BITS-1:0]        point_i,
  input  wire  [8:0][epp_pkg::MAT_W-1:0]    mat_i,
  input  wire  [2:0][COORD_BITS-1:0]        shift_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [2:0][COORD_BITS-1:0]        moved_o
);
  import epp_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int PH_W = C - 15;
  localparam int HP_W = PH_W + MAT_W;
  localparam int LP_W = 17 + MAT_W;
  localparam int HS_W = HP_W + 2;
  localparam int LS_W = LP_W + 2;
  localparam int T_W  = C + 34;
  localparam int V_W  = C + 7;
  localparam logic signed [V_W-1:0] MAXV = {{(V_W-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [V_W-1:0] MINV = {{(V_W-C+1){1'b1}}, {(C-1){1'b0}}};

  logic [3:0] vld_q, rdy;
  logic signed [HP_W-1:0] hp_q [9];
  logic signed [LP_W-1:0] lp_q [9];
  logic signed [HS_W-1:0] hs_q [3];
  logic signed [LS_W-1:0] ls_q [3];
  logic signed [V_W-1:0]  v_q  [3];
  logic [2:0][C-1:0]      out_q;

  logic signed [PH_W-1:0] ph [3];
  logic signed [16:0]     pl [3];
  logic signed [T_W-1:0]  tot [3];

  // per-stage ready: a stage moves when empty or when its successor moves
  always_comb begin
    rdy[3] = !vld_q[3] || out_ready_i;
    rdy[2] = !vld_q[2] || rdy[3];
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
    in_ready_o = rdy[0] && enable_i;
  end

  // coordinate split into a high part and a low 16-bit part, and rounded row totals
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph[k] = PH_W'($signed(point_i[k]) >>> 16);
      pl[k] = $signed({1'b0, point_i[k][15:0]});
    end
    for (int r = 0; r < 3; r++) begin
      tot[r] = (T_W'(hs_q[r]) <<< 16) + T_W'(ls_q[r]) + (T_W'(1) <<< 27);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i && in_ready_o;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 0: products
    if (rdy[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          hp_q[r*3+k] <= ph[k] * $signed(mat_i[r*3+k]);
          lp_q[r*3+k] <= pl[k] * $signed(mat_i[r*3+k]);
        end
      end
    end
    // stage 1: row sums
    if (rdy[1]) begin
      for (int r = 0; r < 3; r++) begin
        hs_q[r] <= HS_W'(hp_q[r*3]) + HS_W'(hp_q[r*3+1]) + HS_W'(hp_q[r*3+2]);
        ls_q[r] <= LS_W'(lp_q[r*3]) + LS_W'(lp_q[r*3+1]) + LS_W'(lp_q[r*3+2]);
      end
    end
    // stage 2: round Q28 product and add translation
    if (rdy[2]) begin
      for (int r = 0; r < 3; r++) begin
        v_q[r] <= V_W'(tot[r] >>> 28) + V_W'($signed(shift_i[r]));
      end
    end
    // stage 3: saturate into the output register
    if (rdy[3]) begin
      for (int r = 0; r < 3; r++) begin
        if (v_q[r] > MAXV) out_q[r] <= MAXV[C-1:0];
        else if (v_q[r] < MINV) out_q[r] <= MINV[C-1:0];
        else out_q[r] <= v_q[r][C-1:0];
      end
    end
  end

  assign out_valid_o = vld_q[3];
  assign moved_o     = out_q;

endmodule
`default_nettype wire

[rtl/euler_pose_point_transform.sv]
// An accepted input word passes the product, row-sum, rounding and saturation registers before its result word leaves.
// Throughput: one point per cycle unless m_axis_tready stalls or a rebuild runs; a stage stalls only when full.
// After reset, and after each write of an angle or the axis order, the
// matrix is rebuilt by the iterative CORDIC and the shared matrix
// multiplier; s_axis_tready stays low meanwhile. Reset is asynchronous,
// active low.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_pose_point_transform
// Applies a configured Euler-angle pose (rotation plus translation) to a
// stream of 3D points with saturation.
// ----------------------------------------------------------------------------
module euler_pose_point_transform #(
  parameter int COORD_BITS   = 32,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int DW  = (COORD_BITS > 32) ? 64 : 32,
  localparam int AW  = (COORD_BITS > 32) ? 6 : 5,
  localparam int TDW = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            psel,
  input  wire            penable,
  input  wire            pwrite,
  input  wire  [AW-1:0]  paddr,
  input  wire  [DW-1:0]  pwdata,
  output logic [DW-1:0]  prdata,
  output logic           pready,
  input  wire            s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire  [TDW-1:0] s_axis_tdata,   // point_x, point_y, point_z, zero pad
  output logic           m_axis_tvalid,
  input  wire            m_axis_tready,
  output logic [TDW-1:0] m_axis_tdata    // moved_x, moved_y, moved_z, zero pad
);
  import epp_pkg::*;

  localparam int C = COORD_BITS;

  logic [2:0][C-1:0]          shift_q;
  logic [2:0][ANGLE_BITS-1:0] angle_q;
  logic [4:0]                 axis_q;

  logic                  wr_en, rebuild, mat_ok;
  logic [2:0]            reg_idx;
  logic [8:0][MAT_W-1:0] mat;
  logic [2:0][C-1:0]     point, moved;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AW-1:AW-3];
  assign rebuild = wr_en && (reg_idx == REG_ANGLE_0 || reg_idx == REG_ANGLE_1 ||
                             reg_idx == REG_ANGLE_2 || reg_idx == REG_AXIS);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      angle_q <= '0;
      axis_q  <= AXIS_ZYX;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHIFT_X: shift_q[0] <= pwdata[C-1:0];
        REG_SHIFT_Y: shift_q[1] <= pwdata[C-1:0];
        REG_SHIFT_Z: shift_q[2] <= pwdata[C-1:0];
        REG_ANGLE_0: angle_q[0] <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_1: angle_q[1] <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_2: angle_q[2] <= pwdata[ANGLE_BITS-1:0];
        REG_AXIS:    axis_q     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SHIFT_X: prdata = DW'(shift_q[0]);
      REG_SHIFT_Y: prdata = DW'(shift_q[1]);
      REG_SHIFT_Z: prdata = DW'(shift_q[2]);
      REG_ANGLE_0: prdata = DW'(angle_q[0]);
      REG_ANGLE_1: prdata = DW'(angle_q[1]);
      REG_ANGLE_2: prdata = DW'(angle_q[2]);
      REG_AXIS:    prdata = DW'(axis_q);
      default:     prdata = '0;
    endcase
  end

  epp_mtx_builder #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_mtx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rebuild_i (rebuild),
    .angles_i  (angle_q),
    .axis_i    (axis_q),
    .ready_o   (mat_ok),
    .mat_o     (mat)
  );

  assign point = s_axis_tdata[3*C-1:0];

  epp_point_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (mat_ok),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .point_i     (point),
    .mat_i       (mat),
    .shift_i     (shift_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .moved_o     (moved)
  );

  assign m_axis_tdata = TDW'(moved);

`ifndef ASSERT_OFF
  // no point enters while the matrix is being rebuilt
  a_no_accept_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> mat_ok)
    else $error("input accepted during matrix rebuild");

  // an angle or axis write starts a rebuild right away
  a_rebuild_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rebuild |=> !s_axis_tready)
    else $error("rebuild did not block input");

  // the cached matrix holds while the builder is idle
  a_mat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mat_ok && $past(mat_ok)) |-> $stable(mat))
    else $error("matrix changed while idle");
`endif

endmodule
`default_nettype wire

[tb/pose_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_checker
// Watches the register port and both point streams. Keeps its own copy of the
// pose, rebuilds the rotation matrix on every pose register write and compares
// each moved point with the one it predicts.
// ----------------------------------------------------------------------------
module pose_checker
  import epp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          moved_count
);

  localparam longint PI_L      = 64'sd3373259426;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam longint ONE_L     = 64'sd1073741824;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  longint shift_q[3];
  longint angle_q[3];
  logic [4:0] axis_q;
  longint rot28[3][3];
  point_t moved_q[$];

  // CORDIC sine / cosine in Q30 of an angle in radians * 8192
  function automatic void cordic_sincos(input longint ang, output longint s,
                                        output longint c);
    longint r, x, y, dx, dy, tab;
    bit neg;
    r = (ang * (64'sd1 <<< (30 - ANGLE_FRAC))) % TWO_PI_L;
    neg = 1'b0;
    x = GAIN_L;
    y = 0;
    if (r > PI_L) r -= TWO_PI_L;
    if (r < -PI_L) r += TWO_PI_L;
    if (r > HALF_PI_L) begin
      r -= PI_L;
      neg = 1'b1;
    end else if (r < -HALF_PI_L) begin
      r += PI_L;
      neg = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      tab = longint'(atan_q30(5'(i)));
      if (r >= 0) begin
        x -= dx; y += dy; r -= tab;
      end else begin
        x += dx; y -= dy; r += tab;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  // compose the three elementary rotations and round to Q28
  function automatic void rebuild_rotation();
    longint acc[3][3], rot[3][3], tmp[3][3];
    longint s, c, sum;
    int code, a, p, q;
    int axes[3];
    code = (axis_q > AXIS_MAX) ? int'(AXIS_ZYX) : int'(axis_q);
    axes[0] = code / 9;
    axes[1] = (code / 3) % 3;
    axes[2] = code % 3;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) acc[i][j] = (i == j) ? ONE_L : 0;
    for (int n = 0; n < 3; n++) begin
      a = axes[n];
      p = (a + 1) % 3;
      q = (a + 2) % 3;
      cordic_sincos(angle_q[n], s, c);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) rot[i][j] = 0;
      rot[a][a] = ONE_L;
      rot[p][p] = c;  rot[p][q] = -s;
      rot[q][p] = s;  rot[q][q] = c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += acc[i][k] * rot[k][j];
          tmp[i][j] = (sum + (64'sd1 <<< 29)) >>> 30;
        end
      acc = tmp;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot28[i][j] = (acc[i][j] + 2) >>> 2;
  endfunction

  // R*p + t with round half up and saturation
  function automatic point_t move_point(input logic [95:0] word);
    longint pt[3], hi, lo, ph, pl, v;
    logic [31:0] res[3];
    point_t o;
    for (int k = 0; k < 3; k++) pt[k] = longint'($signed(word[32*k +: 32]));
    for (int r = 0; r < 3; r++) begin
      hi = 0;
      lo = 0;
      for (int k = 0; k < 3; k++) begin
        ph = pt[k] >>> 16;
        pl = pt[k] - ph * 65536;
        hi += ph * rot28[r][k];
        lo += pl * rot28[r][k];
      end
      lo += 64'sd1 <<< 27;
      v = ((hi + (lo >>> 16)) >>> 12) + shift_q[r];
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      res[r] = v[31:0];
    end
    o.x = res[0];
    o.y = res[1];
    o.z = res[2];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 30)
      $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  initial begin
    fail_count = 0;
    moved_count = 0;
  end

  assign pending_count = moved_q.size();

  // register writes, predictions and comparisons
  always @(posedge clk_i or negedge rst_ni) begin
    point_t got, want;
    logic [2:0] idx;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        shift_q[i] = 0;
        angle_q[i] = 0;
      end
      axis_q = AXIS_ZYX;
      rebuild_rotation();
      moved_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        moved_count++;
        if (moved_q.size() == 0) begin
          fail_count++;
          $display("[%0t] unexpected moved word %h", $time, m_axis_tdata);
        end else begin
          want = moved_q.pop_front();
          if (got.x !== want.x) report_mismatch("moved_x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("moved_y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("moved_z", got.z, want.z);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        moved_q.insert(moved_q.size(), move_point(s_axis_tdata));
      if (psel && penable && pwrite && pready) begin
        idx = paddr[4:2];
        if (idx <= REG_SHIFT_Z) begin
          shift_q[idx] = longint'($signed(pwdata));
          rebuild_rotation();
        end else if (idx <= REG_ANGLE_2) begin
          angle_q[idx - REG_ANGLE_0] = longint'($signed(pwdata[15:0]));
          rebuild_rotation();
        end else if (idx == REG_AXIS) begin
          axis_q = pwdata[4:0];
          rebuild_rotation();
        end
      end
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives poses over the register port and streams of points through the pose
// transform, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import epp_pkg::*;

  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] A_QUARTER = 32'd12868;   // pi/2 * 8192
  localparam logic [31:0] A_PI = 32'd25736;        // pi * 8192

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;    // point_x, point_y, point_z
  logic        m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;    // moved_x, moved_y, moved_z

  int fail_count, pending_count, moved_count;
  int send_idle_pct, recv_idle_pct;
  int pose_count, point_count;
  logic hold_req;
  bit hold_done;
  int hold_left;

  euler_pose_point_transform dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  pose_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count, .pending_count, .moved_count
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    hold_left = 0;
    hold_done = 1'b0;
  end
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // let any matrix rebuild finish before the next write
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // write a whole pose once the stream has drained
  task automatic set_pose(input logic [31:0] sx, sy, sz, a0, a1, a2,
                          input logic [4:0] ax);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    write_reg(REG_ANGLE_0, a0);
    write_reg(REG_ANGLE_1, a1);
    write_reg(REG_ANGLE_2, a2);
    write_reg(REG_AXIS, {27'd0, ax});
    pose_count++;
  endtask

  task automatic send_point(input logic [31:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    point_count++;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  initial begin
    logic [4:0] ax;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 24; recv_idle_pct = 76;
    pose_count = 0; point_count = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);

    // identity pose after reset: extremes pass straight through
    send_point(32'd0, 32'd0, 32'd0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, 32'hffff_ffff);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000);
    s_axis_tvalid <= 1'b0;

    // quarter turns, repeated axes and an unused register address
    set_pose(32'd0, 32'd0, 32'd0, A_QUARTER, A_QUARTER, A_QUARTER, 5'd0);
    write_reg(3'd7, 32'hffff_ffff);
    send_point(C_MAX, C_MIN, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    // half turns: angle folding near pi
    set_pose(32'd0, 32'd0, 32'd0, A_PI, -A_PI, 32'd0, 5'd26);
    send_point(C_MIN, C_MAX, 32'h0001_8000);
    // angle extremes wrap around, axis code above range falls back to Z,Y,X
    set_pose(C_MAX, C_MIN, C_MAX, 32'h0000_7fff, 32'hffff_8000, 32'h0000_7fff, 5'd31);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(32'd0, 32'd0, 32'd0);
    set_pose(C_MIN, C_MAX, C_MIN, 32'hffff_8000, 32'd1, 32'hffff_ffff, 5'd27);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0000_0001);
    s_axis_tvalid <= 1'b0;

    // random poses, each with a burst of random points
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 76; recv_idle_pct = 24;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      ax = (ph == 5) ? AXIS_ZYX : 5'($urandom_range(0, 31));
      set_pose(rand_coord(), rand_coord(), rand_coord(),
               $urandom, $urandom, $urandom, ax);
      for (int n = 0; n < 190; n++) begin
        if (ph == 4 && n == 20) hold_req <= 1'b1;
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      s_axis_tvalid <= 1'b0;
    end

    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d points over %0d poses, %0d moved words checked",
             point_count, pose_count, moved_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[euler_pose_point_transform.f]
rtl/epp_pkg.sv
rtl/epp_angle_unit.sv
rtl/epp_mtx_builder.sv
rtl/epp_point_pipe.sv
rtl/euler_pose_point_transform.sv
tb/pose_checker.sv
tb/testbench.sv
